// File: hw/rtl/rrecs_pkg.sv
// Shared types and constants for the round-robin event port scanner.
package rrecs_pkg;

    // Width of an event port number on the request and result channels.
    localparam int PORT_W = 12;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_RAISE  = 2'd0,
        KIND_MASK   = 2'd1,
        KIND_UNMASK = 2'd2,
        KIND_POLL   = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UPDATE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request, prime the scan pointers
        logic decode;    // split the port number, read its word
        logic update;    // write back a raise, mask or unmask
        logic scan_run;  // advance the poll scan pipeline
        logic emit;      // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // poll found a port or ran out of words
        logic out_free;  // output register can take a result this cycle
    } sts_t;

endpackage

// File: hw/rtl/rrecs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rrecs_ctrl.sv
// Controller state machine: sequences decode, update, scan and result hand-off.
module rrecs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         s_kind,
    output logic               s_ready,
    output rrecs_pkg::cmd_t    cmd,
    input  rrecs_pkg::sts_t    sts
);

    rrecs_pkg::state_t state_reg;
    rrecs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrecs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rrecs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_kind == rrecs_pkg::KIND_POLL) begin
                        state_next = rrecs_pkg::ST_SCAN;
                    end else begin
                        state_next = rrecs_pkg::ST_DECODE;
                    end
                end
            end
            rrecs_pkg::ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = rrecs_pkg::ST_UPDATE;
            end
            rrecs_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = rrecs_pkg::ST_RESULT;
            end
            rrecs_pkg::ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    state_next = rrecs_pkg::ST_RESULT;
                end
            end
            rrecs_pkg::ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = rrecs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrecs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/rrecs_dp.sv
// Datapath: port decode, pending/mask word store, poll scan pipeline, output register.
module rrecs_dp #(
    parameter int WORD_BITS  = 64,
    parameter int WORD_COUNT = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [1:0]                    s_kind,
    input  logic [rrecs_pkg::PORT_W-1:0]  s_port,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          m_found,
    output logic [rrecs_pkg::PORT_W-1:0]  m_event_port,
    input  rrecs_pkg::cmd_t               cmd,
    output rrecs_pkg::sts_t               sts
);

    localparam int PORT_W  = rrecs_pkg::PORT_W;
    localparam int WIDX    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIDX    = $clog2(WORD_BITS);
    localparam int CNT_W   = $clog2(WORD_COUNT + 2);
    localparam int QUO_W   = $clog2(((1 << PORT_W) - 1) / WORD_BITS + 1);
    localparam int SHIFT   = 24;
    localparam int RECIP   = (1 << SHIFT) / WORD_BITS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = PORT_W + RECIP_W;
    localparam int RAM_W   = 2 * WORD_BITS;

    // Request capture
    rrecs_pkg::kind_t   kind_reg, kind_next;
    logic [PORT_W-1:0]  port_reg, port_next;
    logic [QUO_W-1:0]   qe_reg, qe_next;
    logic [PROD_W-1:0]  recip_prod;

    // Decode and update
    logic [PORT_W-1:0]  qd;
    logic [PORT_W-1:0]  rem;
    logic               fix;
    logic [PORT_W-1:0]  rem_fixed;
    logic [QUO_W-1:0]   dec_w;
    logic [BIDX-1:0]    dec_b;
    logic [WIDX-1:0]    dec_idx;
    logic               dec_in_range;
    logic [WIDX-1:0]    upd_word_reg, upd_word_next;
    logic [BIDX-1:0]    upd_bit_reg, upd_bit_next;
    logic               upd_in_range_reg, upd_in_range_next;
    logic [WORD_BITS-1:0] bit_oh;
    logic [WORD_BITS-1:0] new_pend;
    logic [WORD_BITS-1:0] new_mask;

    // Persistent state
    logic [WORD_COUNT-1:0] selector_reg, selector_next;
    logic [WORD_COUNT-1:0] valid_reg, valid_next;
    logic [WIDX-1:0]       resume_word_reg, resume_word_next;
    logic [BIDX-1:0]       resume_bit_reg, resume_bit_next;

    // Scan pipeline
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic [WIDX-1:0]      iss_word_reg, iss_word_next;
    logic                 ex_vld_reg, ex_vld_next;
    logic [CNT_W-1:0]     ex_cnt_reg, ex_cnt_next;
    logic [WIDX-1:0]      ex_word_reg, ex_word_next;
    logic [WORD_BITS-1:0] start_mask_reg, start_mask_next;
    logic                 rd_entry_valid_reg, rd_entry_valid_next;
    logic                 issuing;
    logic                 ex_go;
    logic                 ex_sel;
    logic                 ex_first;
    logic                 ex_last;
    logic                 ex_hit;
    logic                 rest_empty;
    logic [WORD_BITS-1:0] cur_pend;
    logic [WORD_BITS-1:0] cur_mask;
    logic [WORD_BITS-1:0] full_active;
    logic [WORD_BITS-1:0] ex_active;
    logic [WORD_BITS-1:0] low_onehot;
    logic [BIDX-1:0]      low_idx;

    // Result and output registers
    logic                 res_found_reg, res_found_next;
    logic [PORT_W-1:0]    res_port_reg, res_port_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [PORT_W-1:0]    m_event_port_reg, m_event_port_next;

    // RAM ports
    logic                 ram_we;
    logic [WIDX-1:0]      ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [WIDX-1:0]      ram_raddr;
    logic [RAM_W-1:0]     ram_rdata;

    // Mask word in the upper half, pending word in the lower half.
    rrecs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WORD_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [WIDX-1:0] next_word(input logic [WIDX-1:0] w);
        logic [WIDX-1:0] r;
        if (w == WIDX'(WORD_COUNT - 1)) begin
            r = '0;
        end else begin
            r = w + WIDX'(1);
        end
        return r;
    endfunction

    // Quotient estimate by reciprocal; may be one low, fixed in decode.
    assign recip_prod = PROD_W'(s_port) * PROD_W'(RECIP);

    // Decode: correct the estimate, derive word and bit.
    assign qd           = PORT_W'(qe_reg) * PORT_W'(WORD_BITS);
    assign rem          = port_reg - qd;
    assign fix          = (rem >= PORT_W'(WORD_BITS));
    assign rem_fixed    = fix ? (rem - PORT_W'(WORD_BITS)) : rem;
    assign dec_w        = qe_reg + QUO_W'(fix);
    assign dec_b        = rem_fixed[BIDX-1:0];
    assign dec_idx      = dec_w[WIDX-1:0];
    assign dec_in_range = (32'(dec_w) < 32'(WORD_COUNT));

    // Word read back from the store, zero where never written.
    assign cur_pend = rd_entry_valid_reg ? ram_rdata[WORD_BITS-1:0] : '0;
    assign cur_mask = rd_entry_valid_reg ? ram_rdata[RAM_W-1:WORD_BITS] : '0;

    // Examine stage of the scan.
    assign issuing     = cmd.scan_run && (iss_cnt_reg <= CNT_W'(WORD_COUNT));
    assign ex_go       = cmd.scan_run && ex_vld_reg;
    assign ex_sel      = selector_reg[ex_word_reg];
    assign ex_first    = (ex_cnt_reg == '0);
    assign ex_last     = (ex_cnt_reg == CNT_W'(WORD_COUNT));
    assign full_active = cur_pend & ~cur_mask;
    assign ex_active   = full_active & (ex_first ? start_mask_reg : {WORD_BITS{1'b1}});
    assign low_onehot  = ex_active & (~ex_active + WORD_BITS'(1));
    assign ex_hit      = ex_sel && (ex_active != '0);
    assign rest_empty  = ((full_active & ~low_onehot) == '0);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_onehot[i]) begin
                low_idx = low_idx | BIDX'(i);
            end
        end
    end

    assign bit_oh = WORD_BITS'(1) << upd_bit_reg;

    always_comb begin
        new_pend = cur_pend;
        new_mask = cur_mask;
        unique case (kind_reg)
            rrecs_pkg::KIND_RAISE:  new_pend = cur_pend | bit_oh;
            rrecs_pkg::KIND_MASK:   new_mask = cur_mask | bit_oh;
            rrecs_pkg::KIND_UNMASK: new_mask = cur_mask & ~bit_oh;
            rrecs_pkg::KIND_POLL:   new_pend = cur_pend;
        endcase
    end

    always_comb begin
        kind_next           = kind_reg;
        port_next           = port_reg;
        qe_next             = qe_reg;
        upd_word_next       = upd_word_reg;
        upd_bit_next        = upd_bit_reg;
        upd_in_range_next   = upd_in_range_reg;
        selector_next       = selector_reg;
        valid_next          = valid_reg;
        resume_word_next    = resume_word_reg;
        resume_bit_next     = resume_bit_reg;
        iss_cnt_next        = iss_cnt_reg;
        iss_word_next       = iss_word_reg;
        ex_vld_next         = ex_vld_reg;
        ex_cnt_next         = ex_cnt_reg;
        ex_word_next        = ex_word_reg;
        start_mask_next     = start_mask_reg;
        rd_entry_valid_next = rd_entry_valid_reg;
        res_found_next      = res_found_reg;
        res_port_next       = res_port_reg;
        m_valid_next        = m_valid_reg;
        m_found_next        = m_found_reg;
        m_event_port_next   = m_event_port_reg;
        ram_we              = 1'b0;
        ram_waddr           = upd_word_reg;
        ram_wdata           = {new_mask, new_pend};
        ram_re              = 1'b0;
        ram_raddr           = iss_word_reg;

        // Capture the request and prime the scan from the resume position.
        if (cmd.load) begin
            kind_next       = rrecs_pkg::kind_t'(s_kind);
            port_next       = s_port;
            qe_next         = recip_prod[SHIFT +: QUO_W];
            iss_cnt_next    = '0;
            iss_word_next   = resume_word_reg;
            ex_vld_next     = 1'b0;
            start_mask_next = {WORD_BITS{1'b1}} << resume_bit_reg;
        end

        // Read the addressed word.
        if (cmd.decode) begin
            ram_re              = 1'b1;
            ram_raddr           = dec_idx;
            rd_entry_valid_next = dec_in_range && valid_reg[dec_idx];
            upd_word_next       = dec_idx;
            upd_bit_next        = dec_b;
            upd_in_range_next   = dec_in_range;
        end

        // Write back raise, mask or unmask.
        if (cmd.update) begin
            if (upd_in_range_reg) begin
                ram_we                  = 1'b1;
                valid_next[upd_word_reg] = 1'b1;
                if (kind_reg == rrecs_pkg::KIND_RAISE) begin
                    selector_next[upd_word_reg] = 1'b1;
                end else if (kind_reg == rrecs_pkg::KIND_UNMASK &&
                             (cur_pend & bit_oh) != '0) begin
                    selector_next[upd_word_reg] = 1'b1;
                end
            end
            res_found_next = 1'b0;
            res_port_next  = '0;
        end

        // Issue stage: read the next word in round-robin order.
        if (issuing) begin
            ram_re              = 1'b1;
            ram_raddr           = iss_word_reg;
            rd_entry_valid_next = valid_reg[iss_word_reg];
            ex_vld_next         = 1'b1;
            ex_cnt_next         = iss_cnt_reg;
            ex_word_next        = iss_word_reg;
            iss_cnt_next        = iss_cnt_reg + CNT_W'(1);
            iss_word_next       = next_word(iss_word_reg);
        end else if (cmd.scan_run) begin
            ex_vld_next = 1'b0;
        end

        // Examine stage: deliver the lowest ready port or retire empty words.
        if (ex_go) begin
            if (ex_hit) begin
                ram_we    = 1'b1;
                ram_waddr = ex_word_reg;
                ram_wdata = {cur_mask, cur_pend & ~low_onehot};
                if (rest_empty) begin
                    selector_next[ex_word_reg] = 1'b0;
                end
                if (low_idx == BIDX'(WORD_BITS - 1)) begin
                    resume_bit_next  = '0;
                    resume_word_next = next_word(ex_word_reg);
                end else begin
                    resume_bit_next  = low_idx + BIDX'(1);
                    resume_word_next = ex_word_reg;
                end
                res_found_next = 1'b1;
                res_port_next  = PORT_W'(ex_word_reg) * PORT_W'(WORD_BITS) + PORT_W'(low_idx);
            end else begin
                if (ex_sel && !ex_first) begin
                    selector_next[ex_word_reg] = 1'b0;
                end
                if (ex_last) begin
                    res_found_next = 1'b0;
                    res_port_next  = '0;
                end
            end
        end

        // Output register.
        if (cmd.emit) begin
            m_valid_next      = 1'b1;
            m_found_next      = res_found_reg;
            m_event_port_next = res_port_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            selector_reg    <= '0;
            valid_reg       <= '0;
            resume_word_reg <= '0;
            resume_bit_reg  <= '0;
            ex_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            selector_reg    <= selector_next;
            valid_reg       <= valid_next;
            resume_word_reg <= resume_word_next;
            resume_bit_reg  <= resume_bit_next;
            ex_vld_reg      <= ex_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg           <= kind_next;
        port_reg           <= port_next;
        qe_reg             <= qe_next;
        upd_word_reg       <= upd_word_next;
        upd_bit_reg        <= upd_bit_next;
        upd_in_range_reg   <= upd_in_range_next;
        iss_cnt_reg        <= iss_cnt_next;
        iss_word_reg       <= iss_word_next;
        ex_cnt_reg         <= ex_cnt_next;
        ex_word_reg        <= ex_word_next;
        start_mask_reg     <= start_mask_next;
        rd_entry_valid_reg <= rd_entry_valid_next;
        res_found_reg      <= res_found_next;
        res_port_reg       <= res_port_next;
        m_found_reg        <= m_found_next;
        m_event_port_reg   <= m_event_port_next;
    end

    assign sts.scan_done = ex_go && (ex_hit || ex_last);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_event_port = m_event_port_reg;

endmodule

// File: hw/rtl/round_robin_event_channel_scan.sv
// Top level of the round-robin two-level event port pending scanner.
//
//  Channel  Ports                              Direction  Carries
//  s_       s_valid s_ready s_kind s_port      in         request: raise/mask/unmask/poll
//  m_       m_valid m_ready m_found m_event_port out       one result per request
//
// Raise, mask and unmask run these steps between acceptance and the next one:
// decode the port number, read its word, write it back, load the result.
// A poll reads at most WORD_COUNT + 1 words and stops at the first hit; the
// single read port of the word store sets the pace, with reads issued back to
// back and each examined in the cycle after its read.
// Reset (synchronous, aresetn low) clears the word valid bits, selector and
// resume position directly; no clearing pass is needed.
// A stalled m_ready holds the result in the output register; the next request
// is still taken and waits only to hand over its own result.
module round_robin_event_channel_scan #(
    parameter int WORD_BITS  = 64,
    parameter int WORD_COUNT = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic [rrecs_pkg::PORT_W-1:0]  s_port,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [rrecs_pkg::PORT_W-1:0]  m_event_port
);

    // Command and status between controller and datapath.
    rrecs_pkg::cmd_t cmd;
    rrecs_pkg::sts_t sts;

    // Sequence each request: decode/update for port changes, scan for polls.
    rrecs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Hold pending/mask words, selector and resume position; drive results.
    rrecs_dp #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_kind       (s_kind),
        .s_port       (s_port),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_found      (m_found),
        .m_event_port (m_event_port),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the round-robin two-level event port pending scanner.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_TAIL  = 80;      // outlasts the longest poll

    // One expected result per request, oldest first.
    typedef struct packed {
        logic                        found;
        logic [rrecs_pkg::PORT_W-1:0] port;
    } delivery_t;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    rrecs_pkg::kind_t             s_kind  = rrecs_pkg::KIND_RAISE;
    logic [rrecs_pkg::PORT_W-1:0] s_port  = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_found;
    logic [rrecs_pkg::PORT_W-1:0] m_event_port;

    round_robin_event_channel_scan dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_port       (s_port),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_event_port (m_event_port)
    );

    // Shadow copy of the scanner state: 64 words of 64 ports each.
    logic [63:0] pend_words [64];
    logic [63:0] mask_words [64];
    logic [63:0] word_sel;
    logic [5:0]  resume_w;
    logic [5:0]  resume_b;

    delivery_t due_results[$];
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver back-pressure; changes only on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic void log_mismatch(input string msg);
        if (mismatches < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    function automatic void clear_scanner_state();
        for (int i = 0; i < 64; i++) begin
            pend_words[i] = '0;
            mask_words[i] = '0;
        end
        word_sel = '0;
        resume_w = '0;
        resume_b = '0;
    endfunction

    // Advance the shadow state by one request and work out its result.
    // A poll walks the marked words from the resume position: the resume word
    // from resume_b upward first, then every other word in turn, and last the
    // resume word again from bit 0. Wholly scanned empty words lose their mark;
    // the partial first look at the resume word never drops it.
    function automatic delivery_t apply_request(input rrecs_pkg::kind_t kind,
                                                input logic [rrecs_pkg::PORT_W-1:0] port);
        delivery_t   res;
        logic [5:0]  w;
        logic [5:0]  b;
        logic [5:0]  sw;
        logic [63:0] live;
        logic        hit;
        int          lb;

        res = '0;
        w   = port[11:6];
        b   = port[5:0];
        case (kind)
            rrecs_pkg::KIND_RAISE: begin
                // Set pending even when masked; delivery waits for unmask.
                pend_words[w][b] = 1'b1;
                word_sel[w]      = 1'b1;
            end
            rrecs_pkg::KIND_MASK: begin
                mask_words[w][b] = 1'b1;
            end
            rrecs_pkg::KIND_UNMASK: begin
                mask_words[w][b] = 1'b0;
                if (pend_words[w][b])
                    word_sel[w] = 1'b1;
            end
            default: begin
                hit = 1'b0;
                for (int i = 0; i <= 64 && !hit; i++) begin
                    sw = resume_w + 6'(i);
                    if (word_sel[sw]) begin
                        live = pend_words[sw] & ~mask_words[sw];
                        if (i == 0)
                            live &= ~64'd0 << resume_b;
                        if (live == '0) begin
                            if (i != 0)
                                word_sel[sw] = 1'b0;
                        end else begin
                            lb = 0;
                            for (int j = 63; j >= 0; j--)
                                if (live[j])
                                    lb = j;
                            pend_words[sw][lb] = 1'b0;
                            if ((pend_words[sw] & ~mask_words[sw]) == '0)
                                word_sel[sw] = 1'b0;
                            // Resume at the next port, rolling into the next word.
                            resume_w  = (lb == 63) ? sw + 6'd1 : sw;
                            resume_b  = 6'(lb + 1);
                            res.found = 1'b1;
                            res.port  = {sw, 6'(lb)};
                            hit       = 1'b1;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Compare each accepted result against the oldest outstanding request.
    always @(posedge aclk) begin
        delivery_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                log_mismatch($sformatf("unexpected result found=%0d port=%0d",
                                       m_found, m_event_port));
            end else begin
                exp_res = due_results.pop_front();
                if (m_found !== exp_res.found)
                    log_mismatch($sformatf("found: expected %0d, got %0d",
                                           exp_res.found, m_found));
                if (m_event_port !== exp_res.port)
                    log_mismatch($sformatf("event_port: expected %0d, got %0d",
                                           exp_res.port, m_event_port));
            end
        end
    end

    // Present one request and hold it until accepted. Drop valid only for an
    // idle gap, so back-to-back requests never toggle valid within one step.
    task automatic send_request(input rrecs_pkg::kind_t kind,
                                input logic [rrecs_pkg::PORT_W-1:0] port);
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_port  <= port;
        do
            @(posedge aclk);
        while (!s_ready);
        due_results.push_back(apply_request(kind, port));
    endtask

    // Drop valid so the last request is not taken again, then wait for
    // every outstanding result.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic rrecs_pkg::kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return rrecs_pkg::KIND_RAISE;
        else if (r < 47)
            return rrecs_pkg::KIND_MASK;
        else if (r < 60)
            return rrecs_pkg::KIND_UNMASK;
        return rrecs_pkg::KIND_POLL;
    endfunction

    // Hand-picked corners: empty polls, port extremes, word wrap, masking,
    // and a hit found only on the wrap back into the resume word.
    task automatic test_directed_cases();
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // nothing pending
        send_request(rrecs_pkg::KIND_RAISE, 12'd0);
        send_request(rrecs_pkg::KIND_RAISE, 12'd4095);
        send_request(rrecs_pkg::KIND_RAISE, 12'd63);
        send_request(rrecs_pkg::KIND_RAISE, 12'd64);
        send_request(rrecs_pkg::KIND_POLL, 12'd4095);     // port 0
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // last bit of word 0
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // first bit of word 1
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // port 4095, resume wraps
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // empty again
        send_request(rrecs_pkg::KIND_MASK, 12'd5);
        send_request(rrecs_pkg::KIND_RAISE, 12'd5);       // pending while masked
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // masked port is held back
        send_request(rrecs_pkg::KIND_UNMASK, 12'd5);      // re-marks the word
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // port 5, resume at bit 6
        send_request(rrecs_pkg::KIND_RAISE, 12'd2);       // below the resume bit
        send_request(rrecs_pkg::KIND_POLL, 12'd0);        // found on the final pass
        send_request(rrecs_pkg::KIND_UNMASK, 12'd100);    // unmask of an idle port
        send_request(rrecs_pkg::KIND_RAISE, 12'hAAA);
        send_request(rrecs_pkg::KIND_RAISE, 12'h555);
        send_request(rrecs_pkg::KIND_MASK, 12'hFFF);
        send_request(rrecs_pkg::KIND_POLL, 12'hFFF);
        send_request(rrecs_pkg::KIND_POLL, 12'h000);
        send_request(rrecs_pkg::KIND_UNMASK, 12'hFFF);
        send_request(rrecs_pkg::KIND_POLL, 12'd0);
    endtask

    // Random mix of all kinds. Most ports land in a small window of
    // neighboring words so masks, raises and polls interact.
    task automatic test_mixed_traffic(input int count);
        logic [5:0]                   focus;
        logic [rrecs_pkg::PORT_W-1:0] port;
        focus = 6'($urandom_range(0, 63));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 60)
                port = {focus + 6'($urandom_range(0, 3)), 6'($urandom_range(0, 63))};
            else
                port = rrecs_pkg::PORT_W'($urandom_range(0, 4095));
            send_request(pick_kind(), port);
        end
    endtask

    // Raise a burst of ports in a few neighboring words, sometimes mask one,
    // then poll until the burst should be drained; unmask and drain the rest.
    task automatic test_raise_drain_bursts(input int count);
        int                           sent;
        int                           burst;
        logic [5:0]                   base;
        logic [rrecs_pkg::PORT_W-1:0] held;
        logic                         masked;
        sent = 0;
        while (sent < count) begin
            burst  = $urandom_range(1, 12);
            base   = 6'($urandom_range(0, 63));
            masked = ($urandom_range(0, 99) < 30);
            held   = {base, 6'($urandom_range(0, 63))};
            if (masked) begin
                send_request(rrecs_pkg::KIND_MASK, held);
                send_request(rrecs_pkg::KIND_RAISE, held);
                sent += 2;
            end
            for (int k = 0; k < burst; k++)
                send_request(rrecs_pkg::KIND_RAISE,
                             {base + 6'($urandom_range(0, 2)), 6'($urandom_range(0, 63))});
            for (int k = 0; k <= burst; k++)
                send_request(rrecs_pkg::KIND_POLL,
                             rrecs_pkg::PORT_W'($urandom_range(0, 4095)));
            sent += 2 * burst + 1;
            if (masked) begin
                send_request(rrecs_pkg::KIND_UNMASK, held);
                send_request(rrecs_pkg::KIND_POLL, '0);
                send_request(rrecs_pkg::KIND_POLL, '0);
                sent += 3;
            end
        end
    endtask

    initial begin
        clear_scanner_state();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Slow receiver.
        snd_idle_pct = 12;
        rcv_idle_pct = 58;
        test_directed_cases();
        test_mixed_traffic(420);
        test_raise_drain_bursts(200);
        wait_drained();

        // Slow sender.
        snd_idle_pct = 58;
        rcv_idle_pct = 12;
        test_mixed_traffic(420);
        test_raise_drain_bursts(200);
        wait_drained();

        // Full rate on both sides.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_mixed_traffic(420);
        test_raise_drain_bursts(200);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
